// ----- src/mpr_pkg.sv -----
// shared constants, types and reset tables for the recency-ranked palette
package mpr_pkg;

	localparam int SLOTS_DEF = 20;
	localparam int DEFAULT_COUNT = 20;
	localparam int COLOR_W = 24;
	localparam int SLOT_W = 5;
	localparam int RANK_W = 5;

	// request kinds
	localparam logic KIND_SLOT = 1'b0;
	localparam logic KIND_COLOR = 1'b1;

	// control from the sequencer to every cell
	typedef struct packed {
		logic cmp_en;
		logic upd_en;
		logic wr_color;
		logic kind;
		logic hit;
		logic [SLOT_W-1:0] slot;
		logic [COLOR_W-1:0] color;
	} cell_ctrl_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic found;
		logic [RANK_W-1:0] rank_or;
		logic [SLOT_W-1:0] slot_or;
		logic [COLOR_W-1:0] color_or;
	} cell_chain_t;

	typedef struct packed {
		logic sel;
		logic is_last;
		logic is_first;
	} cell_stat_t;

	// standard colors, 0xBBGGRR
	function automatic logic [COLOR_W-1:0] default_color(input int idx);
		logic [COLOR_W-1:0] c;
		case (idx)
			0: c = 24'h000000;
			1: c = 24'h000080;
			2: c = 24'h008000;
			3: c = 24'h008080;
			4: c = 24'h800000;
			5: c = 24'h800080;
			6: c = 24'h808000;
			7: c = 24'hC0C0C0;
			8: c = 24'hC0DCC0;
			9: c = 24'hF0CAA6;
			10: c = 24'hF0FBFF;
			11: c = 24'hA4A0A0;
			12: c = 24'h808080;
			13: c = 24'h0000FF;
			14: c = 24'h00FF00;
			15: c = 24'h00FFFF;
			16: c = 24'hFF0000;
			17: c = 24'hFF00FF;
			18: c = 24'hFFFF00;
			19: c = 24'hFFFFFF;
			default: c = '0;
		endcase
		return c;
	endfunction

	// ranks are held minus one: 0 is most recent, slots-1 least recent
	function automatic logic [RANK_W-1:0] default_rank(input int idx, input int slots);
		int r;
		if (idx < ((slots + 1) >> 1))
			r = 2 * idx;
		else
			r = 2 * (slots - idx) - 1;
		return RANK_W'(r);
	endfunction

endpackage

// ----- src/mpr_if.sv -----
// item channels of the palette block
interface mpr_req_if import mpr_pkg::*; ();
	logic valid;
	logic ready;
	logic kind;
	logic [SLOT_W-1:0] slot;
	logic [COLOR_W-1:0] color;

	modport source (output valid, kind, slot, color, input ready);
	modport sink (input valid, kind, slot, color, output ready);
endinterface

interface mpr_rsp_if import mpr_pkg::*; ();
	logic valid;
	logic ready;
	logic [SLOT_W-1:0] chosen_slot;
	logic [COLOR_W-1:0] chosen_color;
	logic hit;

	modport source (output valid, chosen_slot, chosen_color, hit, input ready);
	modport sink (input valid, chosen_slot, chosen_color, hit, output ready);
endinterface

// ----- src/mru_palette_lru_replace.sv -----
// top level of the recency-ranked color palette with lru replacement
//
// req carries one item: kind, slot and color. kind 0 picks a slot by number
// (numbers past the last slot pick the last one), kind 1 looks the color up.
// rsp returns one item per request: the slot that became most recent, the
// color now in it, and hit (0 when the least recent slot was overwritten).
// Each slot is a cell in a chain; the match and old-rank data ripple along it.
// An item passes a compare step, which compares all cells and marks the chosen
// one, then an update step, which broadcasts its old rank and updates every rank.
// The result lands in an output register at the end of the update step, and the
// next item is taken in that same cycle; no item is taken while one is compared.
// While rsp is stalled with a result pending, an item can still be taken and
// compared; it then waits in the update step until the register frees up.
// Reset restores the standard colors and the interleaved ranks, so the end
// slots (black and white) are the last to be replaced.
module mru_palette_lru_replace import mpr_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	mpr_req_if.sink req,
	mpr_rsp_if.source rsp
);

	typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_UPD} state_t;

	state_t state_q;
	logic kind_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [COLOR_W-1:0] color_s1;
	logic hit_s2;
	logic valid_q;
	logic [SLOT_W-1:0] slot_q;
	logic [COLOR_W-1:0] color_q;
	logic hit_q;
	logic out_free;
	logic accept;
	cell_ctrl_t ctrl;
	cell_chain_t chain [SLOTS+1];
	cell_stat_t stat [SLOTS];
	logic [SLOTS-1:0] sel_vec;
	logic [SLOTS-1:0] last_vec;
	logic [SLOTS-1:0] first_vec;

	assign out_free = !valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE) || (state_q == ST_UPD && out_free);
	assign accept = req.valid && req.ready;

	assign rsp.valid = valid_q;
	assign rsp.chosen_slot = slot_q;
	assign rsp.chosen_color = color_q;
	assign rsp.hit = hit_q;

	always_comb begin
		ctrl.cmp_en = (state_q == ST_CMP);
		ctrl.upd_en = (state_q == ST_UPD) && out_free;
		ctrl.wr_color = (kind_s1 == KIND_COLOR) && !hit_s2;
		ctrl.kind = kind_s1;
		ctrl.hit = chain[SLOTS].found;
		ctrl.slot = slot_s1;
		ctrl.color = color_s1;
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		mpr_cell #(
			.SLOTS(SLOTS),
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.old_rank(chain[SLOTS].rank_or),
			.chain_in(chain[i]),
			.chain_out(chain[i+1]),
			.stat(stat[i])
		);
		assign sel_vec[i] = stat[i].sel;
		assign last_vec[i] = stat[i].is_last;
		assign first_vec[i] = stat[i].is_first;
	end

	// request capture, slot numbers past the end saturate
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= req.kind;
			color_s1 <= req.color;
			if ({1'b0, req.slot} >= (SLOT_W+1)'(SLOTS))
				slot_s1 <= SLOT_W'(SLOTS - 1);
			else
				slot_s1 <= req.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
			hit_s2 <= 1'b0;
			slot_q <= '0;
			color_q <= '0;
			hit_q <= 1'b0;
		end else begin
			// the update step reloads the register itself
			if (rsp.valid && rsp.ready && state_q != ST_UPD)
				valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= ST_CMP;
				end
				ST_CMP: begin
					hit_s2 <= (kind_s1 == KIND_SLOT) || chain[SLOTS].found;
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) begin
						valid_q <= 1'b1;
						slot_q <= chain[SLOTS].slot_or;
						color_q <= (kind_s1 == KIND_COLOR) ? color_s1 : chain[SLOTS].color_or;
						hit_q <= hit_s2;
						state_q <= accept ? ST_CMP : ST_IDLE;
					end else if (rsp.valid && rsp.ready) begin
						valid_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_sel_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD |-> $onehot(sel_vec))
		else $error("update step without exactly one chosen slot");

	a_one_lru: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(last_vec))
		else $error("ranks lost their single least recent slot");

	a_one_mru: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(first_vec))
		else $error("ranks lost their single most recent slot");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPD && out_free |=> valid_q && hit_q == $past(hit_s2))
		else $error("finished update did not load the result register");

endmodule

// ----- src/mpr_cell.sv -----
// one palette slot: color, recency rank and its link in the search chain
module mpr_cell import mpr_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  cell_ctrl_t ctrl,
	input  logic [RANK_W-1:0] old_rank,
	input  cell_chain_t chain_in,
	output cell_chain_t chain_out,
	output cell_stat_t stat
);

	localparam logic [RANK_W-1:0] LAST = RANK_W'(SLOTS - 1);
	localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(IDX);

	logic [COLOR_W-1:0] color_q;
	logic [RANK_W-1:0] rank_q;
	logic sel_q;
	logic match;

	assign match = (color_q == ctrl.color);

	always_comb begin
		chain_out.found = chain_in.found | match;
		chain_out.rank_or = chain_in.rank_or | (sel_q ? rank_q : '0);
		chain_out.slot_or = chain_in.slot_or | (sel_q ? MY_SLOT : '0);
		chain_out.color_or = chain_in.color_or | (sel_q ? color_q : '0);
	end

	assign stat.sel = sel_q;
	assign stat.is_last = (rank_q == LAST);
	assign stat.is_first = (rank_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= default_color(IDX);
			rank_q <= default_rank(IDX, SLOTS);
			sel_q <= 1'b0;
		end else begin
			if (ctrl.cmp_en) begin
				// first match wins a hit, the least recent slot takes a miss
				if (ctrl.kind == KIND_SLOT)
					sel_q <= (ctrl.slot == MY_SLOT);
				else if (ctrl.hit)
					sel_q <= match & ~chain_in.found;
				else
					sel_q <= (rank_q == LAST);
			end
			if (ctrl.upd_en) begin
				if (sel_q) begin
					rank_q <= '0;
					if (ctrl.wr_color)
						color_q <= ctrl.color;
				end else if (rank_q < old_rank) begin
					rank_q <= rank_q + RANK_W'(1);
				end
			end
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// self-checking testbench for the recency-ranked palette with lru replacement
module testbench;
	import mpr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = SLOTS_DEF;
	localparam int RAND_ITEMS = 1200;
	localparam int POOL_SIZE = 28;
	localparam int LONG_HOLD = 300;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic [COLOR_W-1:0] color;
		logic hit;
	} pick_t;

	typedef struct packed {
		logic kind;
		logic [SLOT_W-1:0] slot;
		logic [COLOR_W-1:0] color;
		logic typed;
		pick_t want;
	} dir_row_t;

	typedef struct packed {
		logic typed;
		pick_t want;
	} typed_t;

	localparam int NUM_DIR = 22;
	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		'{KIND_SLOT,  5'd0,  24'hFFFFFF, 1'b1, '{5'd0,  24'h000000, 1'b1}},
		'{KIND_SLOT,  5'd31, 24'h000000, 1'b1, '{5'd19, 24'hFFFFFF, 1'b1}},
		'{KIND_SLOT,  5'd20, 24'h5A5A5A, 1'b1, '{5'd19, 24'hFFFFFF, 1'b1}},
		'{KIND_COLOR, 5'd5,  24'h000000, 1'b1, '{5'd0,  24'h000000, 1'b1}},
		'{KIND_COLOR, 5'd0,  24'hFFFFFF, 1'b1, '{5'd19, 24'hFFFFFF, 1'b1}},
		'{KIND_COLOR, 5'd31, 24'h0000FF, 1'b1, '{5'd13, 24'h0000FF, 1'b1}},
		// first miss after reset lands in the middle slot
		'{KIND_COLOR, 5'd0,  24'h123456, 1'b1, '{5'd10, 24'h123456, 1'b0}},
		'{KIND_COLOR, 5'd0,  24'hFFFFFE, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'h000001, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'h123456, 1'b0, '0},
		'{KIND_SLOT,  5'd1,  24'h000000, 1'b0, '0},
		'{KIND_SLOT,  5'd19, 24'h000000, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'hC0DCC0, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'hF0CAA6, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'hA4A0A0, 1'b0, '0},
		'{KIND_COLOR, 5'd31, 24'h800000, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'hAAAAAA, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'h555555, 1'b0, '0},
		'{KIND_SLOT,  5'd10, 24'hFFFFFF, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'hFFFFFE, 1'b0, '0},
		'{KIND_SLOT,  5'd18, 24'h000000, 1'b0, '0},
		'{KIND_COLOR, 5'd0,  24'h000000, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	mpr_req_if req_ch ();
	mpr_rsp_if rsp_ch ();

	mru_palette_lru_replace #(.SLOTS(SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predicted palette state
	logic [COLOR_W-1:0] pal_color [SLOTS];
	int pal_rank [SLOTS];
	logic [COLOR_W-1:0] color_pool [POOL_SIZE];

	pick_t pick_q [$];
	typed_t typed_q [$];

	int err_cnt = 0;
	int items_sent = 0;
	int results_seen = 0;
	int hit_cnt = 0;
	int miss_cnt = 0;
	int sat_cnt = 0;
	bit hold_rsp = 0;
	bit steady = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function automatic void reset_palette();
		logic [COLOR_W-1:0] std_colors [DEFAULT_COUNT];
		std_colors = '{
			24'h000000, 24'h000080, 24'h008000, 24'h008080, 24'h800000,
			24'h800080, 24'h808000, 24'hC0C0C0, 24'hC0DCC0, 24'hF0CAA6,
			24'hF0FBFF, 24'hA4A0A0, 24'h808080, 24'h0000FF, 24'h00FF00,
			24'h00FFFF, 24'hFF0000, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
		};
		for (int i = 0; i < SLOTS; i++) begin
			pal_color[i] = (i < DEFAULT_COUNT) ? std_colors[i] : '0;
			// interleaved so the end slots are evicted last
			pal_rank[i] = (i < (SLOTS + 1) / 2) ? 2 * i + 1 : 2 * (SLOTS - i);
		end
	endfunction

	function automatic pick_t predict_pick(input logic kind, input logic [SLOT_W-1:0] slot,
			input logic [COLOR_W-1:0] color);
		pick_t r;
		int p;
		int old;
		int best;
		bit found;
		r.hit = 1'b1;
		p = 0;
		found = 0;
		if (kind == KIND_SLOT) begin
			if (slot >= SLOTS) begin
				p = SLOTS - 1;
				sat_cnt++;
			end else begin
				p = slot;
			end
		end else begin
			for (int i = 0; i < SLOTS; i++) begin
				if (!found && pal_color[i] == color) begin
					p = i;
					found = 1;
				end
			end
			if (!found) begin
				best = 0;
				for (int i = 0; i < SLOTS; i++) begin
					if (pal_rank[i] > best) begin
						best = pal_rank[i];
						p = i;
					end
				end
				pal_color[p] = color;
				r.hit = 1'b0;
			end
		end
		old = pal_rank[p];
		for (int i = 0; i < SLOTS; i++) begin
			if (old > pal_rank[i])
				pal_rank[i]++;
		end
		pal_rank[p] = 1;
		if (r.hit)
			hit_cnt++;
		else
			miss_cnt++;
		r.slot = SLOT_W'(p);
		r.color = pal_color[p];
		return r;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// result check first, then the prediction for a newly taken item
	always @(posedge clk) begin
		pick_t got;
		pick_t want;
		typed_t t;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				got.slot = rsp_ch.chosen_slot;
				got.color = rsp_ch.chosen_color;
				got.hit = rsp_ch.hit;
				results_seen++;
				if (pick_q.size() == 0) begin
					$error("result with nothing expected: slot %0d color %06h hit %0d",
						got.slot, got.color, got.hit);
					err_cnt++;
				end else begin
					want = pick_q.pop_front();
					if (got.slot !== want.slot) begin
						$error("chosen_slot: expected %0d, got %0d", want.slot, got.slot);
						err_cnt++;
					end
					if (got.color !== want.color) begin
						$error("chosen_color: expected %06h, got %06h", want.color, got.color);
						err_cnt++;
					end
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						err_cnt++;
					end
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				want = predict_pick(req_ch.kind, req_ch.slot, req_ch.color);
				t = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
				pick_q.push_back(t.typed ? t.want : want);
			end
		end
	end

	// response side ready
	initial begin
		int run;
		int gap;
		rsp_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_rsp = 0;
			end else if (steady) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				run = $urandom_range(1, 12);
				gap = gap_len();
				rsp_ch.ready <= 1'b1;
				repeat (run) @(posedge clk);
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	task automatic drive_item(input logic kind, input logic [SLOT_W-1:0] slot,
			input logic [COLOR_W-1:0] color, input typed_t t);
		typed_q.push_back(t);
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.slot <= slot;
		req_ch.color <= color;
		do
			@(posedge clk);
		while (!req_ch.ready);
		items_sent++;
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			req_ch.valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained(input int limit);
		int n;
		n = 0;
		while (pick_q.size() != 0 && n < limit) begin
			@(posedge clk);
			n++;
		end
	endtask

	initial begin
		int sel;
		logic kind;
		logic [SLOT_W-1:0] slot;
		logic [COLOR_W-1:0] color;
		typed_t t;
		reset_palette();
		for (int i = 0; i < POOL_SIZE; i++)
			color_pool[i] = COLOR_W'($urandom);
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_SLOT;
		req_ch.slot <= '0;
		req_ch.color <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_ROWS[i]) begin
			t.typed = DIR_ROWS[i].typed;
			t.want = DIR_ROWS[i].want;
			drive_item(DIR_ROWS[i].kind, DIR_ROWS[i].slot, DIR_ROWS[i].color, t);
			idle_for(gap_len());
		end
		idle_for(1);
		wait_drained(20000);

		t = '0;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 300)
				hold_rsp = 1;
			steady = (i >= 800 && i < 950);
			// sender stops until everything in flight has come back
			if (i == 600) begin
				idle_for(1);
				wait_drained(20000);
			end
			sel = $urandom_range(0, 99);
			kind = KIND_COLOR;
			slot = SLOT_W'($urandom_range(0, 31));
			color = COLOR_W'($urandom);
			if (sel < 35) begin
				kind = KIND_SLOT;
				if ($urandom_range(0, 7) == 0)
					slot = SLOT_W'($urandom_range(SLOTS, 31));
				else
					slot = SLOT_W'($urandom_range(0, SLOTS - 1));
			end else if (sel < 65) begin
				color = pal_color[$urandom_range(0, SLOTS - 1)];
			end else if (sel < 85) begin
				// pool larger than the palette keeps hits and evictions mixed
				color = color_pool[$urandom_range(0, POOL_SIZE - 1)];
			end
			drive_item(kind, slot, color, t);
			if (i == RAND_ITEMS - 1 || hold_rsp || steady)
				idle_for(i == RAND_ITEMS - 1 ? 1 : 0);
			else
				idle_for(gap_len());
		end
		steady = 0;

		wait_drained(20000);
		repeat (10) @(posedge clk);
		if (pick_q.size() != 0) begin
			$error("%0d results never arrived", pick_q.size());
			err_cnt++;
		end
		$display("sent %0d items (%0d directed), checked %0d results", items_sent, NUM_DIR,
			results_seen);
		$display("%0d hits, %0d replacements, %0d out-of-range slot numbers", hit_cnt, miss_cnt,
			sat_cnt);
		if (err_cnt == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
